@@ hw/rtl/word_entity_classifier_defines.svh @@
// Assertion macros for the word entity classifier.
`ifndef WORD_ENTITY_CLASSIFIER_DEFINES_SVH
`define WORD_ENTITY_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge outside reset.
`define WEC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every clock edge outside reset.
`define WEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WEC_ASSERT_IMPL(label, ante, cons, msg)
`define WEC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hw/rtl/wec_pkg.sv @@
// Shared types and constants for the word entity classifier.
package wec_pkg;

  // Entity class codes.
  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_PERSON = 3'd1;
  localparam logic [2:0] CLS_PLACE  = 3'd2;
  localparam logic [2:0] CLS_ORG    = 3'd3;
  localparam logic [2:0] CLS_NUMBER = 3'd4;
  localparam logic [2:0] CLS_DATE   = 3'd5;

  // Length saturates at this value.
  localparam logic [3:0] LEN_MAX  = 4'd15;
  localparam logic [3:0] LEN_YEAR = 4'd4;
  localparam logic [1:0] TALLY_MAX = 2'd2;

  // Lowercase suffixes, newest byte in the low bits.
  localparam logic [39:0] SUF_VILLE = "ville";
  localparam logic [39:0] SUF_SHIRE = "shire";
  localparam logic [31:0] SUF_BURG  = "burg";
  localparam logic [31:0] SUF_FORD  = "ford";
  localparam logic [31:0] SUF_LAND  = "land";
  localparam logic [23:0] SUF_TON   = "ton";
  localparam logic [31:0] SUF_CORP  = "corp";
  localparam logic [23:0] SUF_INC   = "inc";
  localparam logic [23:0] SUF_LLC   = "llc";
  localparam logic [23:0] SUF_LTD   = "ltd";

  // Running flags of the word seen so far.
  typedef struct packed {
    logic [3:0]  len;
    logic        only_digits;
    logic        only_letters;
    logic        only_date_chars;
    logic        saw_separator;
    logic        first_is_upper;
    logic        first_digit_nonzero;
    logic [1:0]  letter_tally;
    logic        letters_upper;
    logic [39:0] tail;
  } word_flags_t;

  localparam word_flags_t FLAGS_CLEAR = '{
    len:                 4'd0,
    only_digits:         1'b1,
    only_letters:        1'b1,
    only_date_chars:     1'b1,
    saw_separator:       1'b0,
    first_is_upper:      1'b0,
    first_digit_nonzero: 1'b0,
    letter_tally:        2'd0,
    letters_upper:       1'b1,
    tail:                40'd0
  };

endpackage

@@ hw/rtl/wec_track.sv @@
// Running word flags: updated once per accepted byte, cleared after the last byte.
module wec_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                last,
  input  logic [7:0]          char_byte,
  output wec_pkg::word_flags_t flags_upd
);

  wec_pkg::word_flags_t flags_r;
  wec_pkg::word_flags_t flags_nxt;
  logic                 is_upper;
  logic                 is_lower;
  logic                 is_letter;
  logic                 is_digit;
  logic                 is_sep;
  logic [7:0]           lc_byte;

  // Byte classification.
  assign is_upper  = (char_byte >= 8'h41) && (char_byte <= 8'h5a);
  assign is_lower  = (char_byte >= 8'h61) && (char_byte <= 8'h7a);
  assign is_letter = is_upper || is_lower;
  assign is_digit  = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign is_sep    = (char_byte == 8'h2f) || (char_byte == 8'h2d);
  assign lc_byte   = is_upper ? (char_byte + 8'd32) : char_byte;

  // Flags including the current byte.
  always_comb begin
    flags_upd = flags_r;
    if (flags_r.len == 4'd0) begin
      flags_upd.first_is_upper      = is_upper;
      flags_upd.first_digit_nonzero = is_digit && (char_byte != 8'h30);
    end
    if (!is_digit) begin
      flags_upd.only_digits = 1'b0;
    end
    if (!is_letter) begin
      flags_upd.only_letters = 1'b0;
    end
    if (!is_digit && !is_sep) begin
      flags_upd.only_date_chars = 1'b0;
    end
    if (is_sep) begin
      flags_upd.saw_separator = 1'b1;
    end
    if (is_letter) begin
      if (flags_r.letter_tally < wec_pkg::TALLY_MAX) begin
        flags_upd.letter_tally = flags_r.letter_tally + 2'd1;
      end
      if (!is_upper) begin
        flags_upd.letters_upper = 1'b0;
      end
    end
    if (flags_r.len < wec_pkg::LEN_MAX) begin
      flags_upd.len = flags_r.len + 4'd1;
    end
    flags_upd.tail = {flags_r.tail[31:0], lc_byte};
  end

  // Start a fresh word after the last byte.
  assign flags_nxt = last ? wec_pkg::FLAGS_CLEAR : flags_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= wec_pkg::FLAGS_CLEAR;
    end else if (fire) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

@@ hw/rtl/wec_decide.sv @@
// Entity class decision from the finished word's flags and context bits.
module wec_decide (
  input  wec_pkg::word_flags_t flags,
  input  logic                 sentence_start,
  input  logic                 prev_ends_stop,
  output logic [2:0]           entity_class
);

  logic place_hit;
  logic org_hit;

  // Suffix matches on the lowercased tail.
  assign place_hit = (flags.tail[39:0] == wec_pkg::SUF_VILLE) ||
                     (flags.tail[39:0] == wec_pkg::SUF_SHIRE) ||
                     (flags.tail[31:0] == wec_pkg::SUF_BURG)  ||
                     (flags.tail[31:0] == wec_pkg::SUF_FORD)  ||
                     (flags.tail[31:0] == wec_pkg::SUF_LAND)  ||
                     (flags.tail[23:0] == wec_pkg::SUF_TON);
  assign org_hit   = (flags.tail[31:0] == wec_pkg::SUF_CORP) ||
                     (flags.tail[23:0] == wec_pkg::SUF_INC)  ||
                     (flags.tail[23:0] == wec_pkg::SUF_LLC)  ||
                     (flags.tail[23:0] == wec_pkg::SUF_LTD);

  // Priority chain of the classification rules.
  always_comb begin
    if (flags.only_digits) begin
      entity_class = ((flags.len == wec_pkg::LEN_YEAR) && flags.first_digit_nonzero) ?
                     wec_pkg::CLS_DATE : wec_pkg::CLS_NUMBER;
    end else if (flags.saw_separator && flags.only_date_chars) begin
      entity_class = wec_pkg::CLS_DATE;
    end else if ((flags.letter_tally >= wec_pkg::TALLY_MAX) && flags.letters_upper) begin
      entity_class = wec_pkg::CLS_ORG;
    end else if (!flags.first_is_upper || !flags.only_letters) begin
      entity_class = wec_pkg::CLS_NONE;
    end else if (sentence_start || prev_ends_stop) begin
      entity_class = wec_pkg::CLS_NONE;
    end else if (place_hit) begin
      entity_class = wec_pkg::CLS_PLACE;
    end else if (org_hit) begin
      entity_class = wec_pkg::CLS_ORG;
    end else begin
      entity_class = wec_pkg::CLS_PERSON;
    end
  end

endmodule

@@ hw/rtl/wec_out_buf.sv @@
// Result register with a skid entry, so input bytes keep flowing while a result waits.
module wec_out_buf (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [2:0] push_class,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [2:0] out_class,
  output logic       full
);

  logic       out_valid_r;
  logic [2:0] out_class_r;
  logic       skid_valid_r;
  logic [2:0] skid_class_r;
  logic       out_free;

  // The result register can take a new value when empty or draining.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves alongside the valid bits.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_class_r <= skid_class_r;
      end
    end else if (out_free) begin
      if (push) begin
        out_class_r <= push_class;
      end
    end else if (push) begin
      skid_class_r <= push_class;
    end
  end

  assign out_valid = out_valid_r;
  assign out_class = out_class_r;
  assign full      = skid_valid_r;

endmodule

@@ hw/rtl/word_entity_classifier.sv @@
// Top level of the word entity classifier.
// The block takes one byte of a word per transaction and keeps running flags for the
// word in registers. On the byte marked as the word's end it gives one result transaction
// with the entity class (none, person, place, org, number, date). That result shows in the
// cycle after the byte is taken when the result register is empty or draining; otherwise it
// waits in the skid entry until the held result leaves. Bytes are taken back to back, one
// per cycle while in_stall is low: the flag update and the class decision are one short
// pass of logic between the flag registers and the result register. A skid entry behind
// the result register lets bytes keep arriving while a result waits. in_stall is high while
// the skid entry is full, which happens only when a word ends while a held result is
// stalled; it falls in the cycle after the result side takes the held result.
`include "word_entity_classifier_defines.svh"

module word_entity_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_word_end,
  input  logic       in_sentence_start,
  input  logic       in_prev_ends_stop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_entity_class
);

  logic                 in_fire;
  logic                 buf_full;
  logic [2:0]           class_nxt;
  wec_pkg::word_flags_t flags_upd;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  // Flag tracking per byte.
  wec_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .last      (in_word_end),
    .char_byte (in_char_byte),
    .flags_upd (flags_upd)
  );

  // Class decision on the word's flags including the last byte.
  wec_decide u_decide (
    .flags          (flags_upd),
    .sentence_start (in_sentence_start),
    .prev_ends_stop (in_prev_ends_stop),
    .entity_class   (class_nxt)
  );

  // Result register and skid entry.
  wec_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && in_word_end),
    .push_class (class_nxt),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_class  (out_entity_class),
    .full       (buf_full)
  );

  // The skid entry only fills behind a held result.
  `WEC_ASSERT_IMPL(a_skid_behind_out, in_stall, out_valid, "skid full with empty result register")
  // A last byte taken into an empty buffer shows a result next cycle.
  `WEC_ASSERT_NEXT(a_last_gives_result, in_fire && in_word_end && !out_valid, out_valid, "no result")
  // A middle byte taken into an empty buffer gives no result.
  `WEC_ASSERT_NEXT(a_mid_no_result, in_fire && !in_word_end && !out_valid, !out_valid, "stray result")
  // Shown classes are always defined codes.
  `WEC_ASSERT_IMPL(a_class_legal, out_valid, out_entity_class <= wec_pkg::CLS_DATE, "undefined class code")

endmodule
